// ===== sv/window_level_pixel_mapper_macros.svh =====
// Assertion macros shared by the window/level mapper checker.
`ifndef WINDOW_LEVEL_PIXEL_MAPPER_MACROS_SVH
`define WINDOW_LEVEL_PIXEL_MAPPER_MACROS_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define WLPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window_level_pixel_mapper: assertion failed");

// Implication with a fixed delay in cycles, checked outside reset.
`define WLPM_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("window_level_pixel_mapper: delayed assertion failed");

`endif

// ===== sv/wlpm_pkg.sv =====
// Package with the shared types and constants of the window/level mapper.
package wlpm_pkg;

    // Widths fixed by the word formats.
    localparam int PIXEL_BITS     = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int GREY_BITS      = 8;

    // Full-scale display level.
    localparam logic [GREY_BITS-1:0] GREY_MAX = {GREY_BITS{1'b1}};

    // Register reset values.
    localparam logic [CFG_DATA_BITS-1:0] START_RESET = 16'd0;
    localparam logic [CFG_DATA_BITS-1:0] END_RESET   = 16'd3000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_END   = 2'd1;

    // Cycles from the accepting edge to the edge that takes the result:
    // classify, product, one stage per quotient bit, output register.
    localparam int PIPE_LATENCY = 3 + GREY_BITS;

    // Control that travels with each word down the pipeline.
    typedef struct packed {
        logic valid;
        logic clamp;
        logic white;
    } wlpm_ctl_t;

endpackage

// ===== sv/wlpm_cfg_regs.sv =====
// Window start and end configuration registers.
module wlpm_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [wlpm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wlpm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                  cfg_ready,
    output logic [wlpm_pkg::CFG_DATA_BITS-1:0]    window_start,
    output logic [wlpm_pkg::CFG_DATA_BITS-1:0]    window_end
);

    logic [wlpm_pkg::CFG_DATA_BITS-1:0] start_reg;
    logic [wlpm_pkg::CFG_DATA_BITS-1:0] start_next;
    logic [wlpm_pkg::CFG_DATA_BITS-1:0] end_reg;
    logic [wlpm_pkg::CFG_DATA_BITS-1:0] end_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Address decode; unknown indexes are dropped.
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                wlpm_pkg::REG_WINDOW_START: start_next = cfg_data;
                wlpm_pkg::REG_WINDOW_END:   end_next   = cfg_data;
                default:
                begin
                    start_next = start_reg;
                    end_next   = end_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= wlpm_pkg::START_RESET;
            end_reg   <= wlpm_pkg::END_RESET;
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    assign window_start = start_reg;
    assign window_end   = end_reg;

endmodule

// ===== sv/wlpm_front.sv =====
// Front stages: window classification, then the numerator times 255.
module wlpm_front #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    input  logic [wlpm_pkg::PIXEL_BITS-1:0]               pixel_level,
    input  logic [wlpm_pkg::CFG_DATA_BITS-1:0]            window_start,
    input  logic [wlpm_pkg::CFG_DATA_BITS-1:0]            window_end,
    output wlpm_pkg::wlpm_ctl_t                           ctl_o,
    output logic [LEVEL_BITS+wlpm_pkg::GREY_BITS-1:0]     rem_o,
    output logic [LEVEL_BITS-1:0]                         div_o
);

    localparam int PROD_BITS = LEVEL_BITS + wlpm_pkg::GREY_BITS;

    logic [LEVEL_BITS-1:0] lvl;
    logic [LEVEL_BITS-1:0] ws;
    logic [LEVEL_BITS-1:0] we;
    logic                  inverted;

    wlpm_pkg::wlpm_ctl_t   ctl1_next;
    wlpm_pkg::wlpm_ctl_t   ctl1_reg;
    logic [LEVEL_BITS-1:0] num_next;
    logic [LEVEL_BITS-1:0] num_reg;
    logic [LEVEL_BITS-1:0] den_next;
    logic [LEVEL_BITS-1:0] den_reg;

    wlpm_pkg::wlpm_ctl_t   ctl2_reg;
    logic [PROD_BITS-1:0]  prod_next;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [LEVEL_BITS-1:0] den2_reg;

    // Only the low level bits of the sample and the window take part.
    assign lvl      = pixel_level[LEVEL_BITS-1:0];
    assign ws       = window_start[LEVEL_BITS-1:0];
    assign we       = window_end[LEVEL_BITS-1:0];
    assign inverted = (ws > we);

    // Saturate outside the window, else set up the ramp division.
    always_comb
    begin
        ctl1_next.valid = in_valid;
        ctl1_next.clamp = 1'b0;
        ctl1_next.white = 1'b0;
        num_next        = lvl - ws;
        den_next        = we - ws;
        if (!inverted)
        begin
            if (lvl >= we)
            begin
                ctl1_next.clamp = 1'b1;
                ctl1_next.white = 1'b1;
            end
            else if (lvl <= ws)
            begin
                ctl1_next.clamp = 1'b1;
            end
        end
        else
        begin
            num_next = ws - lvl;
            den_next = ws - we;
            if (lvl >= ws)
            begin
                ctl1_next.clamp = 1'b1;
            end
            else if (lvl <= we)
            begin
                ctl1_next.clamp = 1'b1;
                ctl1_next.white = 1'b1;
            end
        end
    end

    // Times 255 as a shift and a subtract.
    assign prod_next = {num_reg, {wlpm_pkg::GREY_BITS{1'b0}}}
                     - {{wlpm_pkg::GREY_BITS{1'b0}}, num_reg};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        prod_reg <= prod_next;
        den2_reg <= den_reg;
    end

    assign ctl_o = ctl2_reg;
    assign rem_o = prod_reg;
    assign div_o = den2_reg;

endmodule

// ===== sv/wlpm_div_stage.sv =====
// One restoring-division stage that settles a single quotient bit.
module wlpm_div_stage #(
    parameter int LEVEL_BITS = 16,
    parameter int BIT_POS    = 0
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  wlpm_pkg::wlpm_ctl_t                           ctl_i,
    input  logic [LEVEL_BITS+wlpm_pkg::GREY_BITS-1:0]     rem_i,
    input  logic [LEVEL_BITS-1:0]                         div_i,
    input  logic [wlpm_pkg::GREY_BITS-1:0]                quo_i,
    output wlpm_pkg::wlpm_ctl_t                           ctl_o,
    output logic [LEVEL_BITS+wlpm_pkg::GREY_BITS-1:0]     rem_o,
    output logic [LEVEL_BITS-1:0]                         div_o,
    output logic [wlpm_pkg::GREY_BITS-1:0]                quo_o
);

    localparam int PROD_BITS = LEVEL_BITS + wlpm_pkg::GREY_BITS;

    logic [PROD_BITS-1:0]               trial;
    logic                               fits;
    logic [PROD_BITS-1:0]               rem_next;
    logic [wlpm_pkg::GREY_BITS-1:0]     quo_next;

    wlpm_pkg::wlpm_ctl_t                ctl_reg;
    logic [PROD_BITS-1:0]               rem_reg;
    logic [LEVEL_BITS-1:0]              div_reg;
    logic [wlpm_pkg::GREY_BITS-1:0]     quo_reg;

    // Compare against the divisor aligned to this bit and subtract if it fits.
    assign trial = {{wlpm_pkg::GREY_BITS{1'b0}}, div_i} << BIT_POS;
    assign fits  = (rem_i >= trial);

    always_comb
    begin
        rem_next          = fits ? (rem_i - trial) : rem_i;
        quo_next          = quo_i;
        quo_next[BIT_POS] = fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_i;
        quo_reg <= quo_next;
    end

    assign ctl_o = ctl_reg;
    assign rem_o = rem_reg;
    assign div_o = div_reg;
    assign quo_o = quo_reg;

endmodule

// ===== sv/window_level_pixel_mapper.sv =====
// Top level of the window/level pixel mapper.
//
// Maps a raw detector sample on pixel_level to an 8-bit grey value on
// display_level through the window held in two registers.
// Input channel: a word is taken at each rising edge with start high and
// busy low. busy never rises, so a new word may be given every cycle.
// Output channel: done is high for one cycle with display_level valid;
// the receiver takes it at the edge that ends that cycle and cannot stall.
// A word passes from the accepting edge to the edge that takes the result
// through one classify stage, one product stage, eight division stages
// (one per quotient bit) and the output register. Throughput is one word
// per cycle, set by the fully pipelined bit-per-stage divider.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 window start,
// 1 window end, others ignored) and cfg_data; cfg_ready is always high.
// Write the window only while no words are in flight.
// Reset clears the pipeline valid bits and done, and sets the window to
// start 0, end 3000.
module window_level_pixel_mapper #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [wlpm_pkg::PIXEL_BITS-1:0]       pixel_level,
    output logic                                  done,
    output logic [wlpm_pkg::GREY_BITS-1:0]        display_level,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wlpm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wlpm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int PROD_BITS = LEVEL_BITS + wlpm_pkg::GREY_BITS;
    localparam int QBITS     = wlpm_pkg::GREY_BITS;

    logic [wlpm_pkg::CFG_DATA_BITS-1:0] window_start;
    logic [wlpm_pkg::CFG_DATA_BITS-1:0] window_end;

    wlpm_pkg::wlpm_ctl_t                ctl_pipe [0:QBITS];
    logic [PROD_BITS-1:0]               rem_pipe [0:QBITS];
    logic [LEVEL_BITS-1:0]              div_pipe [0:QBITS];
    logic [QBITS-1:0]                   quo_pipe [0:QBITS];

    logic                               done_reg;
    logic                               done_next;
    logic [QBITS-1:0]                   display_reg;
    logic [QBITS-1:0]                   display_next;

    // The pipeline takes a word every cycle.
    assign busy = 1'b0;

    // Window registers.
    wlpm_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg_ready    (cfg_ready),
        .window_start (window_start),
        .window_end   (window_end)
    );

    // Classification and product.
    wlpm_front #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .pixel_level  (pixel_level),
        .window_start (window_start),
        .window_end   (window_end),
        .ctl_o        (ctl_pipe[0]),
        .rem_o        (rem_pipe[0]),
        .div_o        (div_pipe[0])
    );

    assign quo_pipe[0] = '0;

    // Divider, most significant quotient bit first.
    for (genvar g = 0; g < QBITS; g++)
    begin : g_div
        wlpm_div_stage #(
            .LEVEL_BITS (LEVEL_BITS),
            .BIT_POS    (QBITS - 1 - g)
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl_i (ctl_pipe[g]),
            .rem_i (rem_pipe[g]),
            .div_i (div_pipe[g]),
            .quo_i (quo_pipe[g]),
            .ctl_o (ctl_pipe[g+1]),
            .rem_o (rem_pipe[g+1]),
            .div_o (div_pipe[g+1]),
            .quo_o (quo_pipe[g+1])
        );
    end

    // Output select: saturated value or the ramp quotient.
    always_comb
    begin
        done_next = ctl_pipe[QBITS].valid;
        if (ctl_pipe[QBITS].clamp)
        begin
            display_next = ctl_pipe[QBITS].white ? wlpm_pkg::GREY_MAX : '0;
        end
        else
        begin
            display_next = quo_pipe[QBITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        display_reg <= display_next;
    end

    assign done          = done_reg;
    assign display_level = display_reg;

endmodule

// ===== sv/wlpm_checker.sv =====
// Port-level checker for the window/level mapper and its bind.
`include "window_level_pixel_mapper_macros.svh"

module wlpm_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  done,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready
);

    // Every accepted word yields its result after the pipeline latency.
    `WLPM_ASSERT_DELAY(a_word_yields_result, clk, rst_n, start && !busy, wlpm_pkg::PIPE_LATENCY, done)

    // A result strobe always traces back to an accepted word.
    `WLPM_ASSERT_IMPLY(a_result_has_source, clk, rst_n, done, $past(start && !busy, wlpm_pkg::PIPE_LATENCY))

    // Register writes are never held off.
    `WLPM_ASSERT_IMPLY(a_cfg_never_stalls, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind window_level_pixel_mapper wlpm_checker u_wlpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== tb/window_level_pixel_mapper_test.sv =====
// Self-checking testbench for the window/level pixel mapper.
`timescale 1ns / 100ps

module window_level_pixel_mapper_test;

    typedef logic [wlpm_pkg::PIXEL_BITS-1:0]     pixel_t;
    typedef logic [wlpm_pkg::GREY_BITS-1:0]      grey_t;
    typedef logic [wlpm_pkg::CFG_DATA_BITS-1:0]  cfg_data_t;
    typedef logic [wlpm_pkg::CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam int CLK_HALF      = 4;
    localparam int DRAIN_CYCLES  = wlpm_pkg::PIPE_LATENCY + 4;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_WORDS   = 100;

    // Register indexes that the block does not implement.
    localparam cfg_index_t REG_SPARE_A = 2'd2;
    localparam cfg_index_t REG_SPARE_B = 2'd3;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    pixel_t                    pixel_level = '0;
    logic                      done;
    grey_t                     display_level;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    cfg_index_t                cfg_index = '0;
    cfg_data_t                 cfg_data = '0;

    // Shadow copy of the window registers.
    cfg_data_t                 shadow_start = wlpm_pkg::START_RESET;
    cfg_data_t                 shadow_end = wlpm_pkg::END_RESET;

    grey_t                     grey_expected[$];
    int                        failures = 0;
    int                        stall_cycles = 0;
    bit                        idle_on = 1'b1;

    window_level_pixel_mapper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pixel_level   (pixel_level),
        .done          (done),
        .display_level (display_level),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Grey value that a level should map to through the given window.
    function automatic grey_t map_grey(input pixel_t lvl,
                                       input cfg_data_t s,
                                       input cfg_data_t e);
        int unsigned l32;
        int unsigned s32;
        int unsigned e32;
        int unsigned quot;
        l32 = 32'(lvl);
        s32 = 32'(s);
        e32 = 32'(e);
        if (s32 <= e32)
        begin
            if (l32 >= e32)
                return wlpm_pkg::GREY_MAX;
            if (l32 <= s32)
                return '0;
            quot = ((l32 - s32) * 255) / (e32 - s32);
        end
        else
        begin
            if (l32 >= s32)
                return '0;
            if (l32 <= e32)
                return wlpm_pkg::GREY_MAX;
            quot = ((s32 - l32) * 255) / (s32 - e32);
        end
        return quot[wlpm_pkg::GREY_BITS-1:0];
    endfunction

    // Random window: wide, narrow, inverted, threshold or at the extremes.
    task automatic pick_window(output cfg_data_t s,
                               output cfg_data_t e);
        int unsigned base;
        int unsigned span;
        base = $urandom_range(65535);
        case ($urandom_range(5))
            0:
            begin
                s = cfg_data_t'($urandom);
                e = cfg_data_t'($urandom);
            end
            1:
            begin
                span = $urandom_range(300);
                s = cfg_data_t'(base);
                e = (base + span > 65535) ? 16'hFFFF : cfg_data_t'(base + span);
            end
            2:
            begin
                e = cfg_data_t'(base);
                s = (base + 300 > 65535) ? 16'hFFFF
                                         : cfg_data_t'(base + $urandom_range(1, 300));
            end
            3:
            begin
                s = cfg_data_t'(base);
                e = cfg_data_t'(base);
            end
            4:
            begin
                s = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                e = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            default:
            begin
                s = cfg_data_t'($urandom_range(4095));
                e = cfg_data_t'($urandom_range(65535, 61440));
            end
        endcase
    endtask

    // Random level, mostly around the window so the ramp gets exercised.
    function automatic pixel_t pick_level(input cfg_data_t s,
                                          input cfg_data_t e);
        int unsigned lo;
        int unsigned hi;
        lo = 32'((s < e) ? s : e);
        hi = 32'((s < e) ? e : s);
        case ($urandom_range(9))
            0, 1:
                return pixel_t'($urandom);
            8:
                return pixel_t'($urandom_range(1) ? lo : hi);
            9:
                return pixel_t'($urandom_range(1) ? (lo > 0 ? lo - 1 : lo + 1)
                                                  : (hi < 65535 ? hi + 1 : hi - 1));
            default:
                return pixel_t'($urandom_range(hi < 65530 ? hi + 5 : 65535,
                                               lo > 5 ? lo - 5 : 0));
        endcase
    endfunction

    // Send one pixel word, with occasional random idle cycles in front of it.
    task automatic send_pixel(input pixel_t lvl);
        while (idle_on && $urandom_range(99) < 15)
        begin
            @(negedge clk);
            start <= 1'b0;
            pixel_level <= pixel_t'($urandom);
        end
        @(negedge clk);
        start <= 1'b1;
        pixel_level <= lvl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        grey_expected.push_back(map_grey(lvl, shadow_start, shadow_end));
    endtask

    // Stop sending and wait until every pixel in flight has come out.
    task automatic wait_drained;
        @(negedge clk);
        start <= 1'b0;
        while (grey_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // One register write; the block must be idle.
    task automatic write_reg(input cfg_index_t idx,
                             input cfg_data_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == wlpm_pkg::REG_WINDOW_START)
            shadow_start = data;
        else if (idx == wlpm_pkg::REG_WINDOW_END)
            shadow_end = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_index <= cfg_index_t'($urandom);
        cfg_data <= cfg_data_t'($urandom);
    endtask

    task automatic set_window(input cfg_data_t s,
                              input cfg_data_t e);
        wait_drained();
        write_reg(wlpm_pkg::REG_WINDOW_START, s);
        write_reg(wlpm_pkg::REG_WINDOW_END, e);
    endtask

    // The window left by reset, start 0 and end 3000.
    task automatic test_reset_window;
        send_pixel(16'd0);
        send_pixel(16'd2999);
        send_pixel(16'd3000);
        send_pixel(16'hFFFF);
    endtask

    // Normal window: black at and below start, white at and above end.
    task automatic test_normal_ramp;
        set_window(16'd1000, 16'd2000);
        send_pixel(16'd1000);
        send_pixel(16'd1001);
        send_pixel(16'd1999);
        send_pixel(16'd2000);
    endtask

    // Start equal to end: the level equal to both maps to white.
    task automatic test_hard_threshold;
        set_window(16'd5000, 16'd5000);
        send_pixel(16'd4999);
        send_pixel(16'd5000);
    endtask

    // Inverted window: high levels black, low levels white.
    task automatic test_inverted_ramp;
        set_window(16'd40000, 16'd10000);
        send_pixel(16'd40000);
        send_pixel(16'd39999);
        send_pixel(16'd10001);
        send_pixel(16'd10000);
    endtask

    // Windows spanning the whole level range in both directions.
    task automatic test_full_range_windows;
        set_window(16'h0000, 16'hFFFF);
        send_pixel(16'hFFFE);
        send_pixel(16'hFFFF);
        set_window(16'hFFFF, 16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h0001);
        send_pixel(16'hFFFE);
    endtask

    // Writes to unimplemented indexes must leave the window alone.
    task automatic test_spare_index;
        set_window(16'd100, 16'd600);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0000);
        send_pixel(16'd350);
    endtask

    // Random windows, each followed by a burst of random pixels.
    task automatic test_random_windows;
        cfg_data_t s;
        cfg_data_t e;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pick_window(s, e);
            wait_drained();
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                          cfg_data_t'($urandom));
            write_reg(wlpm_pkg::REG_WINDOW_START, s);
            write_reg(wlpm_pkg::REG_WINDOW_END, e);
            // Two phases send their words back to back with no gaps at all.
            idle_on = (p != 5 && p != 6);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_pixel(pick_level(s, e));
        end
        idle_on = 1'b1;
    endtask

    // Compare each result word with the oldest expected grey value.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (grey_expected.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, display_level);
                failures++;
            end
            else if (display_level !== grey_expected[0])
            begin
                $display("%0t: display_level expected %0d, actual %0d",
                         $time, grey_expected[0], display_level);
                failures++;
                void'(grey_expected.pop_front());
            end
            else
                void'(grey_expected.pop_front());
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("window_level_pixel_mapper_test: FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;

        test_reset_window();
        test_normal_ramp();
        test_hard_threshold();
        test_inverted_ramp();
        test_full_range_windows();
        test_spare_index();
        test_random_windows();

        wait_drained();
        if (failures == 0 && grey_expected.size() == 0)
            $display("window_level_pixel_mapper_test: PASS");
        else
            $display("window_level_pixel_mapper_test: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wlpm_pkg.sv
sv/wlpm_cfg_regs.sv
sv/wlpm_front.sv
sv/wlpm_div_stage.sv
sv/window_level_pixel_mapper.sv
sv/wlpm_checker.sv
tb/window_level_pixel_mapper_test.sv
